/* rtl/core/cbc_pkg.sv */
// ----------------------------------------------------------------------------
// cbc_pkg
// shared types and constants of the container beam classifier
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

  // depth of the command queue between classifier and emitter
  localparam int unsigned QueueDepthDef = 2;

  // capture command codes
  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_LFRONT = 3'd1,
    CMD_LREAR  = 3'd2,
    CMD_SINGLE = 3'd3,
    CMD_DOUBLE = 3'd4
  } cmd_e;

  // beam patterns as {a1, a2, b1, b2}, 1 = blocked, 0 = clear
  localparam logic [3:0] PatArm        = 4'b1000;
  localparam logic [3:0] PatAllBlocked = 4'b1111;
  localparam logic [3:0] PatRear       = 4'b0011;
  localparam logic [3:0] PatSingleFrt  = 4'b1110;
  localparam logic [3:0] PatDoubleGap  = 4'b1011;
  localparam logic [3:0] PatDoubleChk  = 4'b1101;
  localparam logic [3:0] PatDoubleClr  = 4'b1100;

  // one input sample
  typedef struct packed {
    logic beam_a1;
    logic beam_a2;
    logic beam_d1;
    logic beam_b1;
    logic beam_b2;
    logic beam_d2;
  } sample_t;

  // one result item
  typedef struct packed {
    logic [2:0] capture_cmd;
    logic       last_cmd;
  } result_t;

  // work handed from classifier to emitter
  typedef struct packed {
    logic pair;  // clear followed by long front
    cmd_e cmd;   // single command when pair is low
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/core/cbc_front.sv */
// ----------------------------------------------------------------------------
// cbc_front
// sample change detection, rule evaluation and flag state
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_data_i,
  input  wire logic            accept_i,
  input  wire cbc_pkg::sample_t sample_i,
  output cbc_pkg::push_t       push_o
);
  import cbc_pkg::*;

  typedef struct packed {
    logic armed;
    logic long_box;
    logic single_box;
    logic front_seen;
    logic double_box;
    logic double_check;
  } flags_t;

  logic      polarity_q;
  sample_t   prev_q;
  flags_t    flags_q, flags_d;
  logic      changed;
  logic [3:0] pat;
  logic      has_cmd;
  job_t      job;

  assign changed = (sample_i != prev_q);
  assign pat = {sample_i.beam_a1, sample_i.beam_a2, sample_i.beam_b1, sample_i.beam_b2}
               ^ {4{polarity_q}};

  always_comb begin
    flags_d  = flags_q;
    has_cmd  = 1'b0;
    job.pair = 1'b0;
    job.cmd  = CMD_CLEAR;
    priority if (pat == PatArm) begin
      has_cmd       = 1'b1;
      flags_d.armed = 1'b1;
    end else if (!flags_q.armed) begin
      // idle until armed
    end else if (pat == PatAllBlocked) begin
      if (!flags_q.double_box) begin
        has_cmd            = 1'b1;
        job.pair           = 1'b1;
        flags_d.long_box   = 1'b1;
        flags_d.front_seen = 1'b1;
      end else begin
        flags_d.long_box = 1'b0;
      end
      flags_d.single_box   = 1'b0;
      flags_d.double_check = 1'b0;
    end else if (flags_q.long_box && pat == PatRear) begin
      has_cmd              = 1'b1;
      job.cmd              = CMD_LREAR;
      flags_d.long_box     = 1'b0;
      flags_d.front_seen   = 1'b0;
      flags_d.double_check = 1'b0;
      flags_d.armed        = 1'b0;
    end else if (pat == PatSingleFrt) begin
      flags_d.single_box = 1'b1;
      flags_d.long_box   = 1'b0;
    end else if (flags_q.single_box && pat == PatRear) begin
      has_cmd              = 1'b1;
      job.cmd              = CMD_SINGLE;
      flags_d.single_box   = 1'b0;
      flags_d.long_box     = 1'b0;
      flags_d.double_check = 1'b0;
      flags_d.armed        = 1'b0;
    end else if (flags_q.front_seen && pat == PatDoubleGap) begin
      flags_d.double_box = 1'b1;
      flags_d.long_box   = 1'b0;
    end else if (flags_q.long_box && pat == PatDoubleChk) begin
      flags_d.double_check = 1'b1;
    end else if (flags_q.long_box && flags_q.double_check) begin
      if (pat == PatDoubleClr) begin
        flags_d.double_box = 1'b0;
      end else begin
        flags_d.double_box = 1'b1;
        flags_d.long_box   = 1'b0;
      end
    end else if (flags_q.double_box && pat == PatRear) begin
      has_cmd              = 1'b1;
      job.cmd              = CMD_DOUBLE;
      flags_d.double_box   = 1'b0;
      flags_d.front_seen   = 1'b0;
      flags_d.long_box     = 1'b0;
      flags_d.double_check = 1'b0;
      flags_d.armed        = 1'b0;
    end else begin
      // no rule matches
    end
  end

  assign push_o.valid = accept_i && changed && has_cmd;
  assign push_o.job   = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polarity_q <= 1'b0;
      prev_q     <= '0;
      flags_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        polarity_q <= cfg_data_i;
      end
      if (accept_i && changed) begin
        prev_q  <= sample_i;
        flags_q <= flags_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cbc_queue.sv */
// ----------------------------------------------------------------------------
// cbc_queue
// small fifo of pending command jobs
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_queue #(
  parameter int unsigned Depth = cbc_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cbc_pkg::push_t push_i,
  input  wire logic          pop_i,
  output cbc_pkg::job_t      head_o,
  output cbc_pkg::q_status_t status_o
);
  import cbc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == Full);
  assign do_push = push_i.valid && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cbc_back.sv */
// ----------------------------------------------------------------------------
// cbc_back
// expands queued jobs into result items behind an output register
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cbc_pkg::job_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output cbc_pkg::result_t   out_res_o
);
  import cbc_pkg::*;

  logic    valid_q, valid_d;
  logic    pending_q, pending_d;
  result_t res_q, res_d;
  logic    adv;

  assign adv = !valid_q || !out_stall_i;

  always_comb begin
    valid_d   = valid_q;
    pending_d = pending_q;
    res_d     = res_q;
    pop_o     = 1'b0;
    if (adv) begin
      priority if (pending_q) begin
        // second half of a long front pair
        valid_d   = 1'b1;
        pending_d = 1'b0;
        res_d     = '{capture_cmd: CMD_LFRONT, last_cmd: 1'b1};
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        if (head_i.pair) begin
          pending_d = 1'b1;
          res_d     = '{capture_cmd: CMD_CLEAR, last_cmd: 1'b0};
        end else begin
          res_d = '{capture_cmd: head_i.cmd, last_cmd: 1'b1};
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      pending_q <= pending_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

/* rtl/core/container_beam_classifier.sv */
// ----------------------------------------------------------------------------
// container_beam_classifier
// infrared gate classifier emitting camera capture commands
// ----------------------------------------------------------------------------
// A new six-beam sample can be taken every clock cycle while the command
// queue has room; samples equal to the previous one are absorbed with no
// effect. A sample that triggers a long front emits two results (clear,
// then long front), any other trigger emits one, so the single output
// register of the emitter limits how fast commands drain. The classifier
// and its flags act in the cycle a sample is taken; commands pass through
// the queue and then the output register. The polarity register is written
// through the cfg port, which is always ready; the user must write it only
// while the block is idle, the block itself does not enforce this.
`default_nettype none

module container_beam_classifier #(
  parameter int unsigned QueueDepth = cbc_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire cbc_pkg::sample_t in_req_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output cbc_pkg::result_t out_res_o,
  // polarity register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);
  import cbc_pkg::*;

  push_t     push;
  job_t      head;
  q_status_t q_status;
  logic      pop;
  logic      in_accept;

  // request taken whenever the queue is not full
  assign in_stall_o  = q_status.full;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // front: change detection and rule evaluation
  cbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_accept),
    .sample_i   (in_req_i),
    .push_o     (push)
  );

  // decoupling queue of command jobs
  cbc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // back: result emission
  cbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_status.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  // a non-final result is always the clear half of a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.last_cmd |-> out_res_o.capture_cmd == CMD_CLEAR)
    else $error("non-final result is not a clear command");

  // the long front follows a taken clear in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_res_o.last_cmd
    |=> out_valid_o && out_res_o.last_cmd && out_res_o.capture_cmd == CMD_LFRONT)
    else $error("long front missing after clear");

  // a full queue implies the emitter holds a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> out_valid_o)
    else $error("queue full while output idle");

endmodule

`default_nettype wire

/* dv/container_beam_classifier_checker.sv */
// ----------------------------------------------------------------------------
// container_beam_classifier_checker
// predicts the capture commands of the beam classifier and compares them
// ----------------------------------------------------------------------------
// Watches the sample, result and polarity channels. Every accepted sample
// runs through a model of the gate flags. Any capture commands it causes are
// queued, and each accepted result is compared with the oldest one. The
// number of commands still awaited and the failure count are published with
// nonblocking updates, so the top sees values settled at the clock edge.

module container_beam_classifier_checker
  import cbc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_stall_i,
  input  sample_t           in_req_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_stall_i,
  input  result_t           out_res_i,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic         cfg_data_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        polarity_q;
  sample_t     last_sample;
  logic        armed, long_box, single_box, front_seen, double_box, double_check;
  result_t     expected_captures[$];
  int unsigned fails;

  // run one sample through the gate flags and queue the commands it causes
  task automatic predict_captures(input sample_t s);
    logic [3:0] pat;
    cmd_e       burst[2];
    int         n;
    n = 0;
    if (s == last_sample) return;
    last_sample = s;
    // normalize to 1 = blocked
    pat = {s.beam_a1, s.beam_a2, s.beam_b1, s.beam_b2} ^ {4{polarity_q}};
    if (pat == PatArm) begin
      burst[n++] = CMD_CLEAR;
      armed = 1'b1;
    end else if (armed) begin
      if (pat == PatAllBlocked) begin
        if (!double_box) begin
          burst[n++] = CMD_CLEAR;
          burst[n++] = CMD_LFRONT;
          long_box = 1'b1;
          front_seen = 1'b1;
        end else begin
          long_box = 1'b0;
        end
        single_box = 1'b0;
        double_check = 1'b0;
      end else if (long_box && pat == PatRear) begin
        burst[n++] = CMD_LREAR;
        long_box = 1'b0;
        front_seen = 1'b0;
        double_check = 1'b0;
        armed = 1'b0;
      end else if (pat == PatSingleFrt) begin
        single_box = 1'b1;
        long_box = 1'b0;
      end else if (single_box && pat == PatRear) begin
        burst[n++] = CMD_SINGLE;
        single_box = 1'b0;
        long_box = 1'b0;
        double_check = 1'b0;
        armed = 1'b0;
      end else if (front_seen && pat == PatDoubleGap) begin
        double_box = 1'b1;
        long_box = 1'b0;
      end else if (long_box && pat == PatDoubleChk) begin
        double_check = 1'b1;
      end else if (long_box && double_check) begin
        // a clean gap keeps one long box, anything else means two boxes
        if (pat == PatDoubleClr) begin
          double_box = 1'b0;
        end else begin
          double_box = 1'b1;
          long_box = 1'b0;
        end
      end else if (double_box && pat == PatRear) begin
        burst[n++] = CMD_DOUBLE;
        double_box = 1'b0;
        front_seen = 1'b0;
        long_box = 1'b0;
        double_check = 1'b0;
        armed = 1'b0;
      end
    end
    for (int i = 0; i < n; i++) begin
      expected_captures.push_back('{capture_cmd: burst[i], last_cmd: (i == n - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      polarity_q = 1'b0;
      last_sample = '0;
      armed = 1'b0;
      long_box = 1'b0;
      single_box = 1'b0;
      front_seen = 1'b0;
      double_box = 1'b0;
      double_check = 1'b0;
      expected_captures.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_res_i;
        if (expected_captures.size() == 0) begin
          $error("unexpected capture result: capture_cmd %0d last_cmd %0d",
                 got.capture_cmd, got.last_cmd);
          fails++;
        end else begin
          want = expected_captures.pop_front();
          if (got.capture_cmd !== want.capture_cmd) begin
            $error("capture_cmd: expected %0d, actual %0d", want.capture_cmd,
                   got.capture_cmd);
            fails++;
          end
          if (got.last_cmd !== want.last_cmd) begin
            $error("last_cmd: expected %0d, actual %0d", want.last_cmd, got.last_cmd);
            fails++;
          end
        end
      end
      // a sample taken at the same edge as a write still sees the old polarity
      if (in_valid_i && !in_stall_i) predict_captures(in_req_i);
      if (cfg_valid_i && cfg_ready_i) polarity_q = cfg_data_i;
      pending_o <= expected_captures.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* dv/container_beam_classifier_tb.sv */
// ----------------------------------------------------------------------------
// container_beam_classifier_tb
// stimulus and verdict for the container beam classifier
// ----------------------------------------------------------------------------
// Drives beam samples into the classifier under both polarities, first a
// short hand-made walk through every capture rule, then random traffic made
// mostly of well-formed container passages with noise mixed in. Both sides
// idle at random except in one calm phase. Prediction and comparison live in
// the checker; this module makes stimulus and reports the outcome.

module container_beam_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbc_pkg::*;

  localparam int          ClkPeriod      = 4;
  localparam int          RandomPerPhase = 165;
  // extra cycles after the last command, a sample may still be in flight
  localparam int          DrainCycles    = 8;
  localparam int unsigned CycleLimit     = 400000;

  // patterns as {a1, a2, b1, b2} with 1 = blocked, mapped to raw levels later
  localparam logic [3:0] PatNone    = 4'b0000;
  localparam logic [3:0] PatBroken  = 4'b0101;
  localparam logic [3:0] PatStray   = 4'b0111;

  // directed walk, each entry is {pattern, d1, d2}
  localparam logic [5:0] DirectedSeq [24] = '{
    {PatNone, 2'b00},        // same as the reset sample in the first walk, absorbed there
    {PatAllBlocked, 2'b00},  // not armed yet, ignored
    {PatArm, 2'b00},         // arm, emits clear
    {PatArm, 2'b10},         // only d1 moved, rearms
    {PatAllBlocked, 2'b10},  // clear plus long front
    {PatDoubleChk, 2'b10},   // start double check
    {PatDoubleClr, 2'b10},   // check resolves to one long box
    {PatRear, 2'b10},        // long rear
    {PatArm, 2'b00},
    {PatSingleFrt, 2'b00},   // single box front
    {PatRear, 2'b00},        // single box capture
    {PatArm, 2'b01},
    {PatAllBlocked, 2'b01},
    {PatDoubleGap, 2'b01},   // gap between two boxes
    {PatAllBlocked, 2'b01},  // second front, no command while double
    {PatRear, 2'b01},        // double box capture
    {PatArm, 2'b00},
    {PatAllBlocked, 2'b00},
    {PatDoubleChk, 2'b00},
    {PatBroken, 2'b00},      // double check broken, two boxes
    {PatRear, 2'b00},
    {PatNone, 2'b01},        // no rule matches, sample still stored
    {PatArm, 2'b11},
    {PatStray, 2'b11}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sample_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  int unsigned pending;
  int unsigned fails;

  // no idling on either side while set
  logic        calm = 1'b0;
  // polarity the stimulus is built for
  logic        gate_polarity = 1'b0;
  sample_t     last_sent = '0;
  int unsigned cycles = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  container_beam_classifier u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  container_beam_classifier_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_res_i    (out_res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  // result side backpressure, about a third of the cycles outside calm
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 32);
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("container_beam_classifier test failed");
      $finish;
    end
  end

  // raw beam levels for a blocked-normalized pattern
  function automatic sample_t beam_sample(input logic [3:0] pat, input logic [1:0] d,
                                          input logic pol);
    sample_t    s;
    logic [3:0] raw;
    raw = pat ^ {4{pol}};
    s.beam_a1 = raw[3];
    s.beam_a2 = raw[2];
    s.beam_b1 = raw[1];
    s.beam_b2 = raw[0];
    s.beam_d1 = d[1];
    s.beam_d2 = d[0];
    return s;
  endfunction

  // one sample request, each cycle in front of it idle about a third of the time;
  // valid stays high afterwards so back-to-back requests need no toggle
  task automatic send_sample(input sample_t s);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= s;
    do @(posedge clk); while (in_stall);
    last_sent = s;
  endtask

  // stop requests, wait for every awaited command and let the block settle;
  // one edge first so the count includes the last sample taken
  task automatic drain_gate();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_polarity(input logic pol);
    cfg_valid <= 1'b1;
    cfg_data <= pol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gate_polarity = pol;
  endtask

  task automatic run_directed();
    foreach (DirectedSeq[i]) begin
      send_sample(beam_sample(DirectedSeq[i][5:2], DirectedSeq[i][1:0], gate_polarity));
    end
  endtask

  // mostly complete container passages with random d bits, plus noise,
  // corrupted steps and repeated samples
  task automatic run_random_traffic(input int count);
    logic [3:0] seq[$];
    int         sent;
    sent = 0;
    while (sent < count) begin
      seq.delete();
      if ($urandom_range(0, 3) != 0) begin
        seq.push_back(PatArm);
        case ($urandom_range(0, 3))
          0: begin
            // long box, sometimes through a double check that clears
            seq.push_back(PatAllBlocked);
            if ($urandom_range(0, 1) != 0) begin
              seq.push_back(PatDoubleChk);
              seq.push_back(PatDoubleClr);
            end
            seq.push_back(PatRear);
          end
          1: begin
            seq.push_back(PatSingleFrt);
            seq.push_back(PatRear);
          end
          2: begin
            // two boxes seen through the gap
            seq.push_back(PatAllBlocked);
            seq.push_back(PatDoubleGap);
            seq.push_back(PatAllBlocked);
            seq.push_back(PatRear);
          end
          default: begin
            // double check with a random follow-up
            seq.push_back(PatAllBlocked);
            seq.push_back(PatDoubleChk);
            seq.push_back(4'($urandom));
            seq.push_back(PatRear);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) seq.push_back(4'($urandom));
      end
      foreach (seq[i]) begin
        // an unchanged sample now and then, not counted
        if ($urandom_range(0, 19) == 0) send_sample(last_sent);
        if ($urandom_range(0, 9) == 0) begin
          send_sample(beam_sample(4'($urandom), 2'($urandom), gate_polarity));
        end else begin
          send_sample(beam_sample(seq[i], 2'($urandom), gate_polarity));
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // four phases alternating polarity, the third one without idling
    for (int ph = 0; ph < 4; ph++) begin
      calm <= (ph == 2);
      drain_gate();
      write_polarity(ph[0]);
      if (ph < 2) run_directed();
      run_random_traffic(RandomPerPhase);
    end
    drain_gate();
    if (fails == 0) begin
      $display("container_beam_classifier test passed");
    end else begin
      $display("container_beam_classifier test failed");
    end
    $finish;
  end

endmodule
